### hw/rtl/bam_pkg.sv
// Shared constants, register indexes and pipeline word types for the beam angle mapper.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package bam_pkg;

	// Geometry of the old reference grid and the angle format.
	localparam int MAX_NEW_BEAMS   = 256;
	localparam int OLD_BEAM_COUNT  = 26;
	localparam int ANGLE_FRAC_BITS = 8;

	localparam int ONE_DEG     = 1 << ANGLE_FRAC_BITS;
	localparam int HALF_SPAN   = (OLD_BEAM_COUNT - 1) * ONE_DEG;
	localparam int WRAP_PERIOD = 2 * OLD_BEAM_COUNT * ONE_DEG;
	localparam int GRID_BITS   = ANGLE_FRAC_BITS + 1;

	// Field widths.
	localparam int IDX_W    = 8;
	localparam int START_W  = 16;
	localparam int STEP_W   = 13;
	localparam int TOTAL_W  = 9;
	localparam int PROD_W   = 21;
	localparam int THETA_W  = 22;
	localparam int BANGLE_W = 21;
	localparam int REF_W    = 14;
	localparam int OLD_W    = 5;
	localparam int WEIGHT_W = 9;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// The wrap works on a biased copy of the angle that is never negative, so
	// the remainder by the period is a plain unsigned one.
	localparam int U_W         = THETA_W + 1;
	localparam int OFFSET_K    = ((1 << (THETA_W - 1)) + WRAP_PERIOD - 1) / WRAP_PERIOD;
	localparam int WRAP_OFFSET = OFFSET_K * WRAP_PERIOD + HALF_SPAN;
	localparam int D_W         = $clog2(WRAP_PERIOD);
	localparam int RECIP_SHIFT = 32;
	localparam longint RECIP   = (longint'(1) << RECIP_SHIFT) / WRAP_PERIOD;
	localparam int RECIP_W     = RECIP_SHIFT - D_W + 1;
	localparam int Q_W         = U_W - D_W + 1;
	localparam int LEFT_W      = D_W - GRID_BITS;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BEAM_TOTAL = 2'd2;

	// Reset values of the registers.
	localparam logic [START_W-1:0] START_RESET = 16'hE700;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 13'd512;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 9'd26;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_BEYOND    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_REF_RANGE = 3'd2;

	typedef struct packed {
		logic signed [START_W-1:0] scan_start;
		logic signed [STEP_W-1:0]  scan_step;
		logic [TOTAL_W-1:0]        beam_total;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic                     beyond;
		logic signed [PROD_W-1:0] prod;
	} prod_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]          idx;
		logic                      beyond;
		logic signed [THETA_W-1:0] theta;
		logic [U_W-1:0]            biased;
	} theta_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]          idx;
		logic                      beyond;
		logic signed [THETA_W-1:0] theta;
		logic [U_W-1:0]            biased;
		logic [Q_W-1:0]            quot;
	} quot_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]          idx;
		logic                      beyond;
		logic signed [THETA_W-1:0] theta;
		logic [D_W-1:0]            span_pos;
	} wrap_word_t;

endpackage

### hw/rtl/bam_cfg_regs.sv
// Configuration registers of the beam angle mapper: scan start, scan step, beam total.
// Depends on bam_pkg.
`timescale 1ns / 1ps

module bam_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [bam_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bam_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output bam_pkg::cfg_t                   cfg
);

	logic [bam_pkg::START_W-1:0] start_q;
	logic [bam_pkg::STEP_W-1:0]  step_q;
	logic [bam_pkg::TOTAL_W-1:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= bam_pkg::START_RESET;
			step_q  <= bam_pkg::STEP_RESET;
			total_q <= bam_pkg::TOTAL_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bam_pkg::REG_SCAN_START: begin
					start_q <= cfg_wdata[bam_pkg::START_W-1:0];
				end
				bam_pkg::REG_SCAN_STEP: begin
					step_q <= cfg_wdata[bam_pkg::STEP_W-1:0];
				end
				bam_pkg::REG_BEAM_TOTAL: begin
					total_q <= cfg_wdata[bam_pkg::TOTAL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.scan_start = $signed(start_q);
	assign cfg.scan_step  = $signed(step_q);
	assign cfg.beam_total = total_q;

endmodule

### hw/rtl/bam_angle_gen.sv
// Stages 1 and 2: step times index, then start plus product and the biased wrap operand.
// Depends on bam_pkg.
`timescale 1ns / 1ps

module bam_angle_gen (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bam_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	input  logic [bam_pkg::IDX_W-1:0]    new_beam_number,
	output logic                         valid_s2,
	output bam_pkg::theta_word_t         word_s2
);

	logic                           valid_s1;
	bam_pkg::prod_word_t            word_s1;
	logic [bam_pkg::TOTAL_W-1:0]    total_eff;
	logic signed [bam_pkg::THETA_W-1:0] prod_full;
	logic signed [bam_pkg::THETA_W-1:0] theta_next;
	logic [bam_pkg::U_W-1:0]        biased_next;

	assign total_eff = (cfg.beam_total < bam_pkg::TOTAL_W'(bam_pkg::MAX_NEW_BEAMS))
		? cfg.beam_total : bam_pkg::TOTAL_W'(bam_pkg::MAX_NEW_BEAMS);
	assign prod_full = cfg.scan_step * $signed({1'b0, new_beam_number});

	assign theta_next  = bam_pkg::THETA_W'(cfg.scan_start) + bam_pkg::THETA_W'(word_s1.prod);
	assign biased_next = bam_pkg::U_W'(theta_next) + bam_pkg::U_W'(bam_pkg::WRAP_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		word_s1.idx    <= new_beam_number;
		word_s1.beyond <= {1'b0, new_beam_number} >= total_eff;
		word_s1.prod   <= prod_full[bam_pkg::PROD_W-1:0];

		word_s2.idx    <= word_s1.idx;
		word_s2.beyond <= word_s1.beyond;
		word_s2.theta  <= theta_next;
		word_s2.biased <= biased_next;
	end

endmodule

### hw/rtl/bam_wrap.sv
// Stages 3 and 4: remainder of the biased angle by the wrap period.
// The quotient comes from a reciprocal multiply that may fall one short; one
// compare and subtract corrects it. Depends on bam_pkg.
`timescale 1ns / 1ps

module bam_wrap (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s2,
	input  bam_pkg::theta_word_t   word_s2,
	output logic                   valid_s4,
	output bam_pkg::wrap_word_t    word_s4
);

	localparam int PW = bam_pkg::U_W + bam_pkg::RECIP_W;

	logic                    valid_s3;
	bam_pkg::quot_word_t     word_s3;
	logic [PW-1:0]           recip_prod;
	logic [bam_pkg::U_W-1:0] quot_times_p;
	logic [bam_pkg::U_W-1:0] rem_raw;
	logic [bam_pkg::U_W-1:0] rem_fix;

	assign recip_prod = PW'(word_s2.biased) * PW'(bam_pkg::RECIP);

	assign quot_times_p = bam_pkg::U_W'(word_s3.quot) * bam_pkg::U_W'(bam_pkg::WRAP_PERIOD);
	assign rem_raw      = word_s3.biased - quot_times_p;
	assign rem_fix      = (rem_raw >= bam_pkg::U_W'(bam_pkg::WRAP_PERIOD))
		? rem_raw - bam_pkg::U_W'(bam_pkg::WRAP_PERIOD) : rem_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		word_s3.idx    <= word_s2.idx;
		word_s3.beyond <= word_s2.beyond;
		word_s3.theta  <= word_s2.theta;
		word_s3.biased <= word_s2.biased;
		word_s3.quot   <= recip_prod[bam_pkg::RECIP_SHIFT +: bam_pkg::Q_W];

		word_s4.idx      <= word_s3.idx;
		word_s4.beyond   <= word_s3.beyond;
		word_s4.theta    <= word_s3.theta;
		word_s4.span_pos <= rem_fix[bam_pkg::D_W-1:0];
	end

endmodule

### hw/rtl/bam_grid.sv
// Stage 5: places the wrapped angle on the old beam grid and registers the result word.
// Depends on bam_pkg.
`timescale 1ns / 1ps

module bam_grid (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid_s4,
	input  bam_pkg::wrap_word_t                  word_s4,
	output logic                                 done,
	output logic [bam_pkg::IDX_W-1:0]            beam_number_echo,
	output logic signed [bam_pkg::BANGLE_W-1:0]  beam_angle,
	output logic signed [bam_pkg::REF_W-1:0]     reference_angle,
	output logic                                 was_wrapped,
	output logic                                 blend_mode,
	output logic [bam_pkg::OLD_W-1:0]            left_old_beam,
	output logic [bam_pkg::OLD_W-1:0]            right_old_beam,
	output logic signed [bam_pkg::REF_W-1:0]     left_old_angle,
	output logic signed [bam_pkg::REF_W-1:0]     right_old_angle,
	output logic [bam_pkg::WEIGHT_W-1:0]         blend_weight,
	output logic [bam_pkg::STATUS_W-1:0]         map_status
);

	localparam int AW = bam_pkg::D_W + 2;
	localparam int WW = bam_pkg::GRID_BITS + bam_pkg::WEIGHT_W;

	logic signed [AW-1:0]              ref_full;
	logic                              ref_high;
	logic [bam_pkg::LEFT_W-1:0]        left_raw;
	logic [bam_pkg::LEFT_W:0]          right_raw;
	logic [bam_pkg::GRID_BITS-1:0]     rem;
	logic                              on_grid;
	logic                              clamp;
	logic [bam_pkg::LEFT_W:0]          left_sel;
	logic [bam_pkg::LEFT_W:0]          right_sel;
	logic signed [AW-1:0]              left_ang;
	logic signed [AW-1:0]              right_ang;
	logic [WW-1:0]                     weight_full;

	// The distance from the low grid end is the reference angle plus the half span.
	assign ref_full = $signed({2'b00, word_s4.span_pos}) - AW'(bam_pkg::HALF_SPAN);
	assign ref_high = word_s4.span_pos > bam_pkg::D_W'(2 * bam_pkg::HALF_SPAN);

	assign left_raw  = word_s4.span_pos[bam_pkg::D_W-1:bam_pkg::GRID_BITS];
	assign rem       = word_s4.span_pos[bam_pkg::GRID_BITS-1:0];
	assign on_grid   = rem == '0;
	assign right_raw = {1'b0, left_raw} + (bam_pkg::LEFT_W + 1)'(1);
	assign clamp     = !on_grid
		&& (right_raw > (bam_pkg::LEFT_W + 1)'(bam_pkg::OLD_BEAM_COUNT - 1));

	always_comb begin
		if (on_grid) begin
			left_sel  = {1'b0, left_raw};
			right_sel = {1'b0, left_raw};
		end else if (clamp) begin
			left_sel  = (bam_pkg::LEFT_W + 1)'(bam_pkg::OLD_BEAM_COUNT - 1);
			right_sel = (bam_pkg::LEFT_W + 1)'(bam_pkg::OLD_BEAM_COUNT - 1);
		end else begin
			left_sel  = {1'b0, left_raw};
			right_sel = right_raw;
		end
	end

	assign left_ang  = $signed(AW'(left_sel) << bam_pkg::GRID_BITS) - AW'(bam_pkg::HALF_SPAN);
	assign right_ang = $signed(AW'(right_sel) << bam_pkg::GRID_BITS) - AW'(bam_pkg::HALF_SPAN);
	assign weight_full = (WW'(rem) << bam_pkg::WEIGHT_W) >> bam_pkg::GRID_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		beam_number_echo <= word_s4.idx;
		beam_angle       <= '0;
		reference_angle  <= '0;
		was_wrapped      <= 1'b0;
		blend_mode       <= 1'b0;
		left_old_beam    <= '0;
		right_old_beam   <= '0;
		left_old_angle   <= '0;
		right_old_angle  <= '0;
		blend_weight     <= '0;
		if (word_s4.beyond) begin
			map_status <= bam_pkg::STAT_BEYOND;
		end else begin
			beam_angle      <= word_s4.theta[bam_pkg::BANGLE_W-1:0];
			reference_angle <= ref_full[bam_pkg::REF_W-1:0];
			was_wrapped     <= bam_pkg::THETA_W'(ref_full) != word_s4.theta;
			if (ref_high) begin
				map_status <= bam_pkg::STAT_REF_RANGE;
			end else begin
				map_status      <= bam_pkg::STAT_OK;
				blend_mode      <= !on_grid;
				left_old_beam   <= left_sel[bam_pkg::OLD_W-1:0];
				right_old_beam  <= right_sel[bam_pkg::OLD_W-1:0];
				left_old_angle  <= left_ang[bam_pkg::REF_W-1:0];
				right_old_angle <= right_ang[bam_pkg::REF_W-1:0];
				if (!on_grid && !clamp) begin
					blend_weight <= weight_full[bam_pkg::WEIGHT_W-1:0];
				end
			end
		end
	end

endmodule

### hw/rtl/beam_angle_to_reference_mapper.sv
// Beam angle to reference mapper: a word taken with start passes all register stages
// before done rises for it. Throughput is one word per cycle; busy stays
// low, and the five register stages (multiply, add, reciprocal multiply, remainder
// correct, grid placement) each hold one word. done cannot be held off by the receiver.
// Reset clears all stage valid bits and loads the register defaults at once.
// Depends on bam_pkg, bam_cfg_regs, bam_angle_gen, bam_wrap and bam_grid.
`timescale 1ns / 1ps

module beam_angle_to_reference_mapper (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [bam_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bam_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [bam_pkg::IDX_W-1:0]            new_beam_number,
	output logic                                 done,
	output logic [bam_pkg::IDX_W-1:0]            beam_number_echo,
	output logic signed [bam_pkg::BANGLE_W-1:0]  beam_angle,
	output logic signed [bam_pkg::REF_W-1:0]     reference_angle,
	output logic                                 was_wrapped,
	output logic                                 blend_mode,
	output logic [bam_pkg::OLD_W-1:0]            left_old_beam,
	output logic [bam_pkg::OLD_W-1:0]            right_old_beam,
	output logic signed [bam_pkg::REF_W-1:0]     left_old_angle,
	output logic signed [bam_pkg::REF_W-1:0]     right_old_angle,
	output logic [bam_pkg::WEIGHT_W-1:0]         blend_weight,
	output logic [bam_pkg::STATUS_W-1:0]         map_status
);

	bam_pkg::cfg_t          cfg;
	logic                   valid_s2;
	bam_pkg::theta_word_t   word_s2;
	logic                   valid_s4;
	bam_pkg::wrap_word_t    word_s4;

	// Every stage moves on each cycle, so a new word is always welcome.
	assign busy = 1'b0;

	bam_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bam_angle_gen u_angle (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.in_valid        (start && !busy),
		.new_beam_number (new_beam_number),
		.valid_s2        (valid_s2),
		.word_s2         (word_s2)
	);

	bam_wrap u_wrap (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.word_s2  (word_s2),
		.valid_s4 (valid_s4),
		.word_s4  (word_s4)
	);

	bam_grid u_grid (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_s4         (valid_s4),
		.word_s4          (word_s4),
		.done             (done),
		.beam_number_echo (beam_number_echo),
		.beam_angle       (beam_angle),
		.reference_angle  (reference_angle),
		.was_wrapped      (was_wrapped),
		.blend_mode       (blend_mode),
		.left_old_beam    (left_old_beam),
		.right_old_beam   (right_old_beam),
		.left_old_angle   (left_old_angle),
		.right_old_angle  (right_old_angle),
		.blend_weight     (blend_weight),
		.map_status       (map_status)
	);

endmodule

### tb/beam_map_checker.sv
// Checker for the beam angle to reference mapper: predicts the mapping of every accepted word
// and compares each strobed result against the oldest prediction.
// Depends on bam_pkg for widths, register indexes, reset values and status codes.
`timescale 1ns / 1ps

module beam_map_checker
	import bam_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                        start,
	input  logic                        busy,
	input  logic [IDX_W-1:0]            new_beam_number,
	input  logic                        done,
	input  logic [IDX_W-1:0]            beam_number_echo,
	input  logic signed [BANGLE_W-1:0]  beam_angle,
	input  logic signed [REF_W-1:0]     reference_angle,
	input  logic                        was_wrapped,
	input  logic                        blend_mode,
	input  logic [OLD_W-1:0]            left_old_beam,
	input  logic [OLD_W-1:0]            right_old_beam,
	input  logic signed [REF_W-1:0]     left_old_angle,
	input  logic signed [REF_W-1:0]     right_old_angle,
	input  logic [WEIGHT_W-1:0]         blend_weight,
	input  logic [STATUS_W-1:0]         map_status,
	output int                          error_count,
	output int                          outstanding
);

	typedef struct packed {
		logic [IDX_W-1:0]           echo;
		logic signed [BANGLE_W-1:0] angle;
		logic signed [REF_W-1:0]    ref_angle;
		logic                       wrapped;
		logic                       interp;
		logic [OLD_W-1:0]           left_beam;
		logic [OLD_W-1:0]           right_beam;
		logic signed [REF_W-1:0]    left_angle;
		logic signed [REF_W-1:0]    right_angle;
		logic [WEIGHT_W-1:0]        weight;
		logic [STATUS_W-1:0]        status;
	} map_result_t;

	map_result_t expected_maps[$];
	map_result_t oldest;

	logic signed [START_W-1:0] scan_start;
	logic signed [STEP_W-1:0]  scan_step;
	logic [TOTAL_W-1:0]        beam_total;

	function automatic map_result_t predict_mapping(logic [IDX_W-1:0] idx);
		map_result_t r;
		longint limit, theta, folded, k, span_pos, left, right, rem, weight, ang;
		r = '0;
		weight = 0;
		r.echo = idx;
		limit = (beam_total < MAX_NEW_BEAMS) ? longint'(beam_total) : longint'(MAX_NEW_BEAMS);
		if (longint'(idx) >= limit) begin
			r.status = STAT_BEYOND;
			return r;
		end
		theta = longint'(scan_start) + longint'(scan_step) * longint'(idx);
		// Fold down by whole periods first, then up.
		folded = theta;
		if (folded > HALF_SPAN) begin
			k = (folded - HALF_SPAN + WRAP_PERIOD - 1) / WRAP_PERIOD;
			folded -= k * WRAP_PERIOD;
		end
		if (folded < -HALF_SPAN) begin
			k = (-HALF_SPAN - folded + WRAP_PERIOD - 1) / WRAP_PERIOD;
			folded += k * WRAP_PERIOD;
		end
		r.angle = theta[BANGLE_W-1:0];
		r.ref_angle = folded[REF_W-1:0];
		r.wrapped = (folded != theta);
		if (folded > HALF_SPAN || folded < -HALF_SPAN) begin
			r.status = STAT_REF_RANGE;
			return r;
		end
		span_pos = folded + HALF_SPAN;
		left = span_pos / (2 * ONE_DEG);
		rem = span_pos - left * (2 * ONE_DEG);
		if (rem == 0) begin
			right = left;
			r.interp = 1'b0;
		end else begin
			right = left + 1;
			r.interp = 1'b1;
			if (right > OLD_BEAM_COUNT - 1) begin
				left = OLD_BEAM_COUNT - 1;
				right = left;
			end else begin
				weight = (rem << WEIGHT_W) >> (ANGLE_FRAC_BITS + 1);
			end
		end
		r.left_beam = left[OLD_W-1:0];
		r.right_beam = right[OLD_W-1:0];
		ang = -HALF_SPAN + 2 * ONE_DEG * left;
		r.left_angle = ang[REF_W-1:0];
		ang = -HALF_SPAN + 2 * ONE_DEG * right;
		r.right_angle = ang[REF_W-1:0];
		r.weight = weight[WEIGHT_W-1:0];
		r.status = STAT_OK;
		return r;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_start <= START_RESET;
			scan_step <= STEP_RESET;
			beam_total <= TOTAL_RESET;
			expected_maps.delete();
			error_count = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SCAN_START: scan_start <= cfg_wdata[START_W-1:0];
					REG_SCAN_STEP: scan_step <= cfg_wdata[STEP_W-1:0];
					REG_BEAM_TOTAL: beam_total <= cfg_wdata[TOTAL_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				expected_maps.insert(expected_maps.size(), predict_mapping(new_beam_number));
			end
			if (done) begin
				if (expected_maps.size() == 0) begin
					$error("result word for beam %0d arrived with nothing expected",
						beam_number_echo);
					error_count++;
				end else begin
					oldest = expected_maps.pop_front();
					check_field("beam_number_echo", oldest.echo, beam_number_echo);
					check_field("beam_angle", oldest.angle, beam_angle);
					check_field("reference_angle", oldest.ref_angle, reference_angle);
					check_field("was_wrapped", oldest.wrapped, was_wrapped);
					check_field("blend_mode", oldest.interp, blend_mode);
					check_field("left_old_beam", oldest.left_beam, left_old_beam);
					check_field("right_old_beam", oldest.right_beam, right_old_beam);
					check_field("left_old_angle", oldest.left_angle, left_old_angle);
					check_field("right_old_angle", oldest.right_angle, right_old_angle);
					check_field("blend_weight", oldest.weight, blend_weight);
					check_field("map_status", oldest.status, map_status);
				end
			end
		end
		outstanding = expected_maps.size();
	end

endmodule

### tb/testbench.sv
// Top of the mapper testbench: clock, reset, register settings and beam index stimulus.
// Instantiates beam_angle_to_reference_mapper and beam_map_checker; depends on bam_pkg.
`timescale 1ns / 1ps

module testbench;
	import bam_pkg::*;

	localparam int LATENCY = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int BATCH_ITEMS = 170;
	localparam int BATCHES_PER_MODE = 4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
	logic                    start = 1'b0;
	logic [IDX_W-1:0]        new_beam_number = '0;
	logic                    busy;
	logic                    done;
	logic [IDX_W-1:0]        beam_number_echo;
	logic signed [BANGLE_W-1:0] beam_angle;
	logic signed [REF_W-1:0] reference_angle;
	logic                    was_wrapped;
	logic                    blend_mode;
	logic [OLD_W-1:0]        left_old_beam;
	logic [OLD_W-1:0]        right_old_beam;
	logic signed [REF_W-1:0] left_old_angle;
	logic signed [REF_W-1:0] right_old_angle;
	logic [WEIGHT_W-1:0]     blend_weight;
	logic [STATUS_W-1:0]     map_status;

	int error_count;
	int outstanding;
	int cycle_count = 0;
	int sender_idle_pct = 10;
	int active_total = TOTAL_RESET;

	always #10 clk = ~clk;

	beam_angle_to_reference_mapper i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.new_beam_number(new_beam_number),
		.done(done),
		.beam_number_echo(beam_number_echo),
		.beam_angle(beam_angle),
		.reference_angle(reference_angle),
		.was_wrapped(was_wrapped),
		.blend_mode(blend_mode),
		.left_old_beam(left_old_beam),
		.right_old_beam(right_old_beam),
		.left_old_angle(left_old_angle),
		.right_old_angle(right_old_angle),
		.blend_weight(blend_weight),
		.map_status(map_status)
	);

	beam_map_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.new_beam_number(new_beam_number),
		.done(done),
		.beam_number_echo(beam_number_echo),
		.beam_angle(beam_angle),
		.reference_angle(reference_angle),
		.was_wrapped(was_wrapped),
		.blend_mode(blend_mode),
		.left_old_beam(left_old_beam),
		.right_old_beam(right_old_beam),
		.left_old_angle(left_old_angle),
		.right_old_angle(right_old_angle),
		.blend_weight(blend_weight),
		.map_status(map_status),
		.error_count(error_count),
		.outstanding(outstanding)
	);

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// All tasks below start and end just after a rising edge.
	task automatic send_beam(logic [IDX_W-1:0] beam);
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			start <= 1'b0;
			new_beam_number <= IDX_W'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		new_beam_number <= beam;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// The extra edge makes sure a word taken at the current edge is already counted.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic load_config(int start_val, int step_val, int total_val);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_SCAN_START;
		cfg_wdata <= CFG_DATA_W'(start_val);
		@(posedge clk);
		cfg_index <= REG_SCAN_STEP;
		cfg_wdata <= CFG_DATA_W'(step_val);
		@(posedge clk);
		cfg_index <= REG_BEAM_TOTAL;
		cfg_wdata <= CFG_DATA_W'(total_val);
		@(posedge clk);
		// The spare index holds no register and must leave the mapping alone.
		cfg_index <= REG_SPARE;
		cfg_wdata <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		active_total = total_val & ((1 << TOTAL_W) - 1);
	endtask

	task automatic random_config();
		int kind;
		kind = $urandom_range(3, 0);
		case (kind)
			0: begin
				load_config(int'($urandom_range(46080, 0)) - 23040,
					int'($urandom_range(5120, 0)) - 2560, $urandom_range(256, 1));
			end
			1: begin
				// Grid-aligned start and step give direct hits on every beam.
				load_config(512 * (int'($urandom_range(89, 0)) - 32) - 6400,
					512 * (int'($urandom_range(10, 0)) - 5), $urandom_range(256, 1));
			end
			2: begin
				load_config($urandom, $urandom, $urandom);
			end
			default: begin
				load_config($urandom_range(1, 0) ? 23040 : -23040,
					$urandom_range(1, 0) ? 2560 : -2560, $urandom_range(1, 0) ? 256 : 1);
			end
		endcase
	endtask

	function automatic logic [IDX_W-1:0] pick_beam();
		int limit;
		limit = (active_total < MAX_NEW_BEAMS) ? active_total : MAX_NEW_BEAMS;
		if (limit > 0 && $urandom_range(99, 0) < 80) return IDX_W'($urandom_range(limit - 1, 0));
		return IDX_W'($urandom_range(255, 0));
	endfunction

	initial begin
		int idle_modes[3];
		idle_modes = '{10, 68, 0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: first, middle and last beam, then just past and far past the total.
		send_beam(0);
		send_beam(13);
		send_beam(25);
		send_beam(26);
		send_beam(255);

		// Widest scan, downward from the top of the range, with several folds.
		wait_drained();
		load_config(23040, -2560, 256);
		send_beam(0);
		send_beam(9);
		send_beam(18);
		send_beam(255);

		// Smallest and largest interpolation weights.
		wait_drained();
		load_config(-6399, 1, 256);
		send_beam(0);
		send_beam(255);
		wait_drained();
		load_config(-5889, 0, 256);
		send_beam(7);

		// Last grid beam, then the gap just above it that falls outside the span.
		wait_drained();
		load_config(6400, 1, 2);
		send_beam(0);
		send_beam(1);
		send_beam(2);
		wait_drained();
		load_config(-6401, -1, 1);
		send_beam(0);
		send_beam(255);

		// A total of zero flags everything; a total above the maximum is clamped.
		wait_drained();
		load_config(-23040, 2560, 0);
		send_beam(0);
		wait_drained();
		load_config(-23040, 2560, 511);
		send_beam(255);
		send_beam(0);

		foreach (idle_modes[m]) begin
			sender_idle_pct = idle_modes[m];
			for (int b = 0; b < BATCHES_PER_MODE; b++) begin
				wait_drained();
				random_config();
				for (int n = 0; n < BATCH_ITEMS; n++) begin
					if (n == BATCH_ITEMS / 2) wait_drained();
					send_beam(pick_beam());
				end
			end
		end

		wait_drained();
		repeat (2 * LATENCY) @(posedge clk);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/bam_pkg.sv
hw/rtl/bam_cfg_regs.sv
hw/rtl/bam_angle_gen.sv
hw/rtl/bam_wrap.sv
hw/rtl/bam_grid.sv
hw/rtl/beam_angle_to_reference_mapper.sv
tb/beam_map_checker.sv
tb/testbench.sv
